// ----- rtl/agcm_pkg.sv -----
// ----------------------------------------------------------------------------
// agcm_pkg
// shared types, constants and aes helper functions for the aes-256-gcm engine
// ----------------------------------------------------------------------------
package agcm_pkg;

    // round key store geometry
    localparam int NUM_ROWS   = 15;
    localparam int ROW_W      = 4;
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(NUM_ROWS - 1);

    // gcm and aes constants
    localparam logic [127:0] GF_POLY   = {8'he1, 120'd0};
    localparam logic [31:0]  RCON_INIT = 32'h0100_0000;
    localparam logic [7:0]   XT_POLY   = 8'h1b;

    // message length counter default width
    localparam int LENGTH_BITS_DEF = 40;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE0 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE1 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd6;

    // full block byte count
    localparam logic [4:0] FULL_COUNT = 5'd16;

    // round key write bundle from the key schedule to the aes core
    typedef struct packed {
        logic             we;
        logic [ROW_W-1:0] row;
        logic [127:0]     data;
    } rk_wr_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // xtime in gf(2^8)
    function automatic logic [7:0] xt(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? XT_POLY : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // one aes round without the key addition; byte 0 sits in the top bits
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic lst);
        logic [7:0]   b [16];
        logic [7:0]   t [16];
        logic [7:0]   o [16];
        logic [127:0] r;
        logic [7:0]   a0, a1, a2, a3;
        for (int i = 0; i < 16; i++) begin
            b[i] = SBOX[s[127-8*i -: 8]];
        end
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[i+4*c] = b[i + 4*((c+i)%4)];
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = t[4*c];
            a1 = t[4*c+1];
            a2 = t[4*c+2];
            a3 = t[4*c+3];
            o[4*c]   = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
            o[4*c+1] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
            o[4*c+2] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
            o[4*c+3] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
        end
        for (int i = 0; i < 16; i++) begin
            r[127-8*i -: 8] = lst ? t[i] : o[i];
        end
        return r;
    endfunction

endpackage

// ----- rtl/agcm_key_sched.sv -----
// ----------------------------------------------------------------------------
// agcm_key_sched
// aes-256 key expansion, one 128-bit round key row per cycle
// ----------------------------------------------------------------------------
module agcm_key_sched (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [255:0]         key,
    output logic                 busy,
    output agcm_pkg::rk_wr_t     rk_wr
);

    logic                        busy_reg, busy_next;
    logic [agcm_pkg::ROW_W-1:0]  row_reg, row_next;
    logic [127:0]                prev2_reg, prev2_next;
    logic [127:0]                prev_reg, prev_next;
    logic [31:0]                 rc_reg, rc_next;
    logic [31:0]                 t, w0, w1, w2, w3;
    logic [127:0]                new_row;

    // next row from the two rows before it
    always_comb begin
        if (!row_reg[0]) begin
            t = agcm_pkg::sub_word({prev_reg[23:0], prev_reg[31:24]}) ^ rc_reg;
        end else begin
            t = agcm_pkg::sub_word(prev_reg[31:0]);
        end
        w0 = prev2_reg[127:96] ^ t;
        w1 = prev2_reg[95:64]  ^ w0;
        w2 = prev2_reg[63:32]  ^ w1;
        w3 = prev2_reg[31:0]   ^ w2;
        new_row = {w0, w1, w2, w3};
    end

    // sequencing
    always_comb begin
        busy_next  = busy_reg;
        row_next   = row_reg;
        prev2_next = prev2_reg;
        prev_next  = prev_reg;
        rc_next    = rc_reg;
        if (start) begin
            busy_next  = 1'b1;
            row_next   = '0;
            prev2_next = key[255:128];
            prev_next  = key[127:0];
            rc_next    = agcm_pkg::RCON_INIT;
        end else if (busy_reg) begin
            row_next = row_reg + 1'b1;
            if (row_reg >= agcm_pkg::ROW_W'(2)) begin
                prev2_next = prev_reg;
                prev_next  = new_row;
                if (!row_reg[0]) begin
                    rc_next = {rc_reg[30:0], 1'b0};
                end
            end
            if (row_reg == agcm_pkg::LAST_ROW) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            row_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            row_reg  <= row_next;
        end
        prev2_reg <= prev2_next;
        prev_reg  <= prev_next;
        rc_reg    <= rc_next;
    end

    // write port towards the round key store
    always_comb begin
        rk_wr.we  = busy_reg;
        rk_wr.row = row_reg;
        if (row_reg == '0) begin
            rk_wr.data = prev2_reg;
        end else if (row_reg == agcm_pkg::ROW_W'(1)) begin
            rk_wr.data = prev_reg;
        end else begin
            rk_wr.data = new_row;
        end
    end

    assign busy = busy_reg;

endmodule

// ----- rtl/agcm_aes_core.sv -----
// ----------------------------------------------------------------------------
// agcm_aes_core
// iterative aes-256 encryption, one round per cycle, with round key store
// ----------------------------------------------------------------------------
module agcm_aes_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  agcm_pkg::rk_wr_t     rk_wr,
    input  logic                 start,
    input  logic [127:0]         blk_in,
    output logic                 busy,
    output logic                 done,
    output logic [127:0]         blk_out
);

    logic [127:0]                rk_mem [agcm_pkg::NUM_ROWS];
    logic [127:0]                rk_q;
    logic [agcm_pkg::ROW_W-1:0]  rd_addr;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [agcm_pkg::ROW_W-1:0]  cnt_reg, cnt_next;
    logic [127:0]                st_reg, st_next;

    // round key store, registered read
    always_ff @(posedge aclk) begin
        if (rk_wr.we) begin
            rk_mem[rk_wr.row] <= rk_wr.data;
        end
        rk_q <= rk_mem[rd_addr];
    end

    // fetch the row for the next round
    always_comb begin
        if (start || !busy_reg || cnt_reg == agcm_pkg::LAST_ROW) begin
            rd_addr = '0;
        end else begin
            rd_addr = cnt_reg + 1'b1;
        end
    end

    // round sequencing
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        st_next   = st_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            st_next   = blk_in;
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                st_next = st_reg ^ rk_q;
            end else begin
                st_next = agcm_pkg::aes_round(st_reg, cnt_reg == agcm_pkg::LAST_ROW) ^ rk_q;
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == agcm_pkg::LAST_ROW) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        st_reg <= st_next;
    end

    assign busy    = busy_reg;
    assign done    = done_reg;
    assign blk_out = st_reg;

endmodule

// ----- rtl/agcm_ghash.sv -----
// ----------------------------------------------------------------------------
// agcm_ghash
// ghash accumulator with a digit-serial gf(2^128) multiplier, 8 bits a cycle
// ----------------------------------------------------------------------------
module agcm_ghash (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          clear,
    input  logic          start,
    input  logic [127:0]  blk,
    input  logic [127:0]  hkey,
    output logic          busy,
    output logic [127:0]  acc
);

    logic          busy_reg, busy_next;
    logic [3:0]    cnt_reg, cnt_next;
    logic [127:0]  x_reg, x_next;
    logic [127:0]  z_reg, z_next;
    logic [127:0]  v_reg, v_next;
    logic [127:0]  acc_reg, acc_next;
    logic [127:0]  zs, vs;

    // eight multiplier bits per cycle, msb first
    always_comb begin
        zs = z_reg;
        vs = v_reg;
        for (int j = 0; j < 8; j++) begin
            if (x_reg[127-j]) begin
                zs = zs ^ vs;
            end
            vs = (vs >> 1) ^ (vs[0] ? agcm_pkg::GF_POLY : '0);
        end
    end

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        z_next    = z_reg;
        v_next    = v_reg;
        acc_next  = acc_reg;
        if (clear) begin
            acc_next = '0;
        end else if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            x_next    = acc_reg ^ blk;
            z_next    = '0;
            v_next    = hkey;
        end else if (busy_reg) begin
            z_next   = zs;
            v_next   = vs;
            x_next   = {x_reg[119:0], 8'd0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == '1) begin
                busy_next = 1'b0;
                acc_next  = zs;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            acc_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            acc_reg  <= acc_next;
        end
        x_reg <= x_next;
        z_reg <= z_next;
        v_reg <= v_next;
    end

    assign busy = busy_reg;
    assign acc  = acc_reg;

endmodule

// ----- rtl/aes256_gcm_seal_open.sv -----
// ----------------------------------------------------------------------------
// aes256_gcm_seal_open
// aes-256-gcm seal and open engine, 96-bit nonce, no additional data
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  cfg_*     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//  s_*       in   s_valid/s_ready      data, byte count, last, expected tag
//  m_*       out  m_valid/m_ready      result data, count, tag, tag_valid, auth_ok
//
//  first transaction of a message: key expansion plus two aes passes
//  (hash subkey, tag mask) before the block itself
//  a block is paced by the single aes round unit (key addition, then the rounds);
//  ghash of a block runs in its own unit alongside the next block
//  last transaction: ghash passes for the data and the length block
//  reset is synchronous active low; a stalled m_ready holds the engine in its
//  output stage, s_ready is high only while idle
// ----------------------------------------------------------------------------
module aes256_gcm_seal_open #(
    parameter int LENGTH_BITS = agcm_pkg::LENGTH_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [agcm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                    cfg_data,
    // input blocks
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [63:0]                    s_data_upper,
    input  logic [63:0]                    s_data_lower,
    input  logic [4:0]                     s_byte_count,
    input  logic                           s_last_block,
    input  logic [63:0]                    s_expected_tag_upper,
    input  logic [63:0]                    s_expected_tag_lower,
    // results
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [63:0]                    m_out_upper,
    output logic [63:0]                    m_out_lower,
    output logic [4:0]                     m_out_count,
    output logic [63:0]                    m_tag_upper,
    output logic [63:0]                    m_tag_lower,
    output logic                           m_tag_valid,
    output logic                           m_auth_ok
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_KEY   = 4'd1;
    localparam logic [3:0] S_HSUB  = 4'd2;
    localparam logic [3:0] S_TMASK = 4'd3;
    localparam logic [3:0] S_CTR   = 4'd4;
    localparam logic [3:0] S_KS    = 4'd5;
    localparam logic [3:0] S_FOLD  = 4'd6;
    localparam logic [3:0] S_LEN   = 4'd7;
    localparam logic [3:0] S_TAG   = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    // configuration registers
    logic [63:0]               key0_reg, key1_reg, key2_reg, key3_reg;
    logic [63:0]               nonce0_reg;
    logic [31:0]               nonce1_reg;
    logic                      mode_cfg_reg;

    // sequencer and message state
    logic [3:0]                state_reg, state_next;
    logic                      in_msg_reg, in_msg_next;
    logic [31:0]               ctr_reg, ctr_next;
    logic [127:0]              hsub_reg, hsub_next;
    logic [127:0]              tmask_reg, tmask_next;
    logic [LENGTH_BITS-1:0]    mbytes_reg, mbytes_next;

    // current transaction
    logic [127:0]              data_reg, data_next;
    logic [127:0]              mask_reg, mask_next;
    logic [4:0]                n_reg, n_next;
    logic                      last_reg, last_next;
    logic                      mode_reg, mode_next;
    logic [127:0]              exp_reg, exp_next;
    logic [127:0]              res_reg, res_next;
    logic [127:0]              tag_reg, tag_next;
    logic                      ok_reg, ok_next;

    // output stage
    logic                      m_valid_reg, m_valid_next;
    logic [127:0]              m_data_reg, m_data_next;
    logic [4:0]                m_count_reg, m_count_next;
    logic [127:0]              m_tag_reg, m_tag_next;
    logic                      m_tagv_reg, m_tagv_next;
    logic                      m_ok_reg, m_ok_next;

    // unit handshakes
    logic                      s_accept;
    logic                      ks_start, ks_busy;
    agcm_pkg::rk_wr_t          rk_wr;
    logic                      aes_start, aes_busy, aes_done;
    logic [127:0]              aes_blk, aes_out;
    logic                      gh_clear, gh_start, gh_busy;
    logic [127:0]              gh_blk, gh_acc;
    logic [4:0]                n_sat;
    logic [127:0]              in_mask;
    logic [63:0]               len_lo;
    logic [127:0]              tag_calc;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign s_accept  = s_valid && s_ready;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key0_reg     <= '0;
            key1_reg     <= '0;
            key2_reg     <= '0;
            key3_reg     <= '0;
            nonce0_reg   <= '0;
            nonce1_reg   <= '0;
            mode_cfg_reg <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                agcm_pkg::REG_KEY0:   key0_reg     <= cfg_data;
                agcm_pkg::REG_KEY1:   key1_reg     <= cfg_data;
                agcm_pkg::REG_KEY2:   key2_reg     <= cfg_data;
                agcm_pkg::REG_KEY3:   key3_reg     <= cfg_data;
                agcm_pkg::REG_NONCE0: nonce0_reg   <= cfg_data;
                agcm_pkg::REG_NONCE1: nonce1_reg   <= cfg_data[31:0];
                agcm_pkg::REG_MODE:   mode_cfg_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // byte count saturation and leading byte mask
    always_comb begin
        n_sat = (s_byte_count > agcm_pkg::FULL_COUNT) ? agcm_pkg::FULL_COUNT : s_byte_count;
        for (int i = 0; i < 16; i++) begin
            in_mask[127-8*i -: 8] = (5'(i) < n_sat) ? 8'hff : 8'h00;
        end
    end

    assign len_lo   = {{(64-LENGTH_BITS){1'b0}}, mbytes_reg} << 3;
    assign tag_calc = gh_acc ^ tmask_reg;

    // sequencer
    always_comb begin
        state_next   = state_reg;
        in_msg_next  = in_msg_reg;
        ctr_next     = ctr_reg;
        hsub_next    = hsub_reg;
        tmask_next   = tmask_reg;
        mbytes_next  = mbytes_reg;
        data_next    = data_reg;
        mask_next    = mask_reg;
        n_next       = n_reg;
        last_next    = last_reg;
        mode_next    = mode_reg;
        exp_next     = exp_reg;
        res_next     = res_reg;
        tag_next     = tag_reg;
        ok_next      = ok_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_count_next = m_count_reg;
        m_tag_next   = m_tag_reg;
        m_tagv_next  = m_tagv_reg;
        m_ok_next    = m_ok_reg;
        ks_start     = 1'b0;
        aes_start    = 1'b0;
        aes_blk      = '0;
        gh_clear     = 1'b0;
        gh_start     = 1'b0;
        gh_blk       = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    data_next = {s_data_upper, s_data_lower} & in_mask;
                    mask_next = in_mask;
                    n_next    = n_sat;
                    last_next = s_last_block;
                    mode_next = mode_cfg_reg;
                    exp_next  = {s_expected_tag_upper, s_expected_tag_lower};
                    res_next  = '0;
                    tag_next  = '0;
                    ok_next   = 1'b0;
                    if (!in_msg_reg) begin
                        ks_start   = 1'b1;
                        state_next = S_KEY;
                    end else begin
                        state_next = S_CTR;
                    end
                end
            end
            S_KEY: begin
                if (!ks_busy) begin
                    aes_start  = 1'b1;
                    state_next = S_HSUB;
                end
            end
            S_HSUB: begin
                if (aes_done) begin
                    hsub_next  = aes_out;
                    aes_start  = 1'b1;
                    aes_blk    = {nonce0_reg, nonce1_reg, 32'd1};
                    state_next = S_TMASK;
                end
            end
            S_TMASK: begin
                if (aes_done) begin
                    tmask_next  = aes_out;
                    ctr_next    = 32'd1;
                    mbytes_next = '0;
                    in_msg_next = 1'b1;
                    gh_clear    = 1'b1;
                    state_next  = S_CTR;
                end
            end
            S_CTR: begin
                if (n_reg != '0) begin
                    aes_start  = 1'b1;
                    aes_blk    = {nonce0_reg, nonce1_reg, ctr_reg + 32'd1};
                    ctr_next   = ctr_reg + 32'd1;
                    state_next = S_KS;
                end else if (last_reg) begin
                    state_next = S_LEN;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_KS: begin
                if (aes_done) begin
                    res_next   = (data_reg ^ aes_out) & mask_reg;
                    state_next = S_FOLD;
                end
            end
            S_FOLD: begin
                if (!gh_busy) begin
                    gh_start    = 1'b1;
                    gh_blk      = mode_reg ? data_reg : res_reg;
                    mbytes_next = mbytes_reg + LENGTH_BITS'(n_reg);
                    state_next  = last_reg ? S_LEN : S_OUT;
                end
            end
            S_LEN: begin
                if (!gh_busy) begin
                    gh_start   = 1'b1;
                    gh_blk     = {64'd0, len_lo};
                    state_next = S_TAG;
                end
            end
            S_TAG: begin
                if (!gh_busy) begin
                    tag_next    = tag_calc;
                    ok_next     = mode_reg ? (tag_calc == exp_reg) : 1'b1;
                    in_msg_next = 1'b0;
                    state_next  = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    m_count_next = n_reg;
                    m_tag_next   = tag_reg;
                    m_tagv_next  = last_reg;
                    m_ok_next    = ok_reg;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            in_msg_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            ctr_reg     <= '0;
            hsub_reg    <= '0;
            tmask_reg   <= '0;
            mbytes_reg  <= '0;
        end else begin
            state_reg   <= state_next;
            in_msg_reg  <= in_msg_next;
            m_valid_reg <= m_valid_next;
            ctr_reg     <= ctr_next;
            hsub_reg    <= hsub_next;
            tmask_reg   <= tmask_next;
            mbytes_reg  <= mbytes_next;
        end
        data_reg    <= data_next;
        mask_reg    <= mask_next;
        n_reg       <= n_next;
        last_reg    <= last_next;
        mode_reg    <= mode_next;
        exp_reg     <= exp_next;
        res_reg     <= res_next;
        tag_reg     <= tag_next;
        ok_reg      <= ok_next;
        m_data_reg  <= m_data_next;
        m_count_reg <= m_count_next;
        m_tag_reg   <= m_tag_next;
        m_tagv_reg  <= m_tagv_next;
        m_ok_reg    <= m_ok_next;
    end

    // units
    agcm_key_sched u_key_sched (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ks_start),
        .key     ({key0_reg, key1_reg, key2_reg, key3_reg}),
        .busy    (ks_busy),
        .rk_wr   (rk_wr)
    );

    agcm_aes_core u_aes_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rk_wr   (rk_wr),
        .start   (aes_start),
        .blk_in  (aes_blk),
        .busy    (aes_busy),
        .done    (aes_done),
        .blk_out (aes_out)
    );

    agcm_ghash u_ghash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (gh_clear),
        .start   (gh_start),
        .blk     (gh_blk),
        .hkey    (hsub_reg),
        .busy    (gh_busy),
        .acc     (gh_acc)
    );

    // result ports
    assign m_valid     = m_valid_reg;
    assign m_out_upper = m_data_reg[127:64];
    assign m_out_lower = m_data_reg[63:0];
    assign m_out_count = m_count_reg;
    assign m_tag_upper = m_tag_reg[127:64];
    assign m_tag_lower = m_tag_reg[63:0];
    assign m_tag_valid = m_tagv_reg;
    assign m_auth_ok   = m_ok_reg;

`ifndef SYNTHESIS
    // aes unit is never restarted mid-block
    a_aes_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        aes_start |-> !aes_busy) else $error("aes start while busy");

    // ghash unit is never restarted mid-multiply
    a_gh_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        gh_start |-> !gh_busy) else $error("ghash start while busy");

    // no key expansion overlaps an aes pass
    a_ks_aes_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        ks_busy |-> !aes_busy) else $error("key expansion during aes pass");

    // a non-final result never carries a pass flag
    a_ok_only_tag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tagv_reg) |-> !m_ok_reg) else $error("auth flag without tag");
`endif

endmodule
